// ===== rtl/b32l_pkg.sv =====
package b32l_pkg;

    localparam int ID_BYTES    = 32;
    localparam int GROUP_CHARS = 13;
    localparam int SPLIT_POINT = 7;
    localparam int GROUP_COUNT = 4;
    localparam int MAX_RESULTS = 4;

    localparam logic [6:0] DASH_CHAR = 7'h2D;
    localparam logic [6:0] ALPHA_BASE = 7'h41;
    localparam logic [6:0] DIGIT_BASE = 7'h32;

    typedef struct packed {
        logic [6:0] out_char;
        logic       is_check;
        logic       last_char;
    } entry_t;

    // base32 alphabet: A-Z then 2-7
    function automatic logic [6:0] symbol_char(input logic [4:0] code);
        logic [6:0] c;
        if (code < 5'd26) begin
            c = ALPHA_BASE + {2'b00, code};
        end else begin
            c = DIGIT_BASE + {2'b00, code - 5'd26};
        end
        return c;
    endfunction

endpackage

// ===== rtl/base32_id_luhn_formatter_unit.sv =====
// Formats a 32-byte identifier, one byte per input transaction (most significant
// bit first), as 63 ASCII characters: four groups of 13 base32 symbols, a '-' after
// the 7th symbol of each group, a Luhn mod 32 check symbol after the 13th, and a '-'
// between groups. Each byte yields one to four characters; the check symbol of the
// last group carries m_last_char and the next byte starts a new identifier. A byte
// is registered on acceptance and expanded into its characters, which are registered
// in turn, once the characters of the previous byte have drained. Throughput is set by
// the result channel, one character per cycle while m_ready is held and bytes arrive.
// A new byte is taken while the characters of the previous one drain.
module base32_id_luhn_formatter_unit
    import b32l_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_id_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [6:0] m_out_char,
    output logic       m_is_check,
    output logic       m_last_char
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    logic [4:0]  byte_index_reg,    byte_index_next;
    logic [3:0]  bit_buffer_reg,    bit_buffer_next;
    logic [3:0]  bits_held_reg,     bits_held_next;
    logic [3:0]  char_in_group_reg, char_in_group_next;
    logic [1:0]  group_index_reg,   group_index_next;
    logic [4:0]  check_sum_reg,     check_sum_next;
    logic        weight_is_two_reg, weight_is_two_next;

    entry_t      ent_reg [MAX_RESULTS];
    entry_t      ent_next [MAX_RESULTS];
    logic [2:0]  cnt_reg,  cnt_next;
    logic [2:0]  idx_reg;

    logic        bundle_free;
    logic        load;
    logic        out_fire;
    logic        last_byte;

    assign m_valid  = (idx_reg != cnt_reg);
    assign out_fire = m_valid && m_ready;
    assign bundle_free = !m_valid || (out_fire && ((idx_reg + 3'd1) == cnt_reg));
    assign load     = in_valid_reg && bundle_free;
    assign s_ready  = !in_valid_reg || load;
    assign last_byte = (byte_index_reg == 5'(ID_BYTES - 1));

    assign m_out_char  = ent_reg[idx_reg[1:0]].out_char;
    assign m_is_check  = ent_reg[idx_reg[1:0]].is_check;
    assign m_last_char = ent_reg[idx_reg[1:0]].last_char;

    always_comb begin : expand
        logic [11:0] bits_v;
        logic [3:0]  held_v;
        logic [4:0]  code_v;
        logic [5:0]  prod_v;
        logic [3:0]  cig_v;
        logic [1:0]  grp_v;
        logic [4:0]  sum_v;
        logic        w_v;
        logic [2:0]  cnt_v;
        logic [4:0]  chk_v;
        logic        fin_v;
        logic        emit_v;

        bits_v = {bit_buffer_reg, in_byte_reg};
        held_v = bits_held_reg + 4'd8;
        cig_v  = char_in_group_reg;
        grp_v  = group_index_reg;
        sum_v  = check_sum_reg;
        w_v    = weight_is_two_reg;
        cnt_v  = 3'd0;
        code_v = 5'd0;
        prod_v = 6'd0;
        chk_v  = 5'd0;
        fin_v  = 1'b0;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            ent_next[i] = '0;
        end

        for (int k = 0; k < 3; k++) begin
            emit_v = 1'b0;
            if (k < 2) begin
                if (held_v >= 4'd5) begin
                    code_v = 5'(bits_v >> (held_v - 4'd5));
                    held_v = held_v - 4'd5;
                    bits_v = bits_v & ((12'd1 << held_v) - 12'd1);
                    emit_v = 1'b1;
                end
            end else if (last_byte && held_v != 4'd0) begin
                code_v = 5'(bits_v << (4'd5 - held_v));
                held_v = 4'd0;
                bits_v = 12'd0;
                emit_v = 1'b1;
            end

            if (emit_v) begin
                ent_next[cnt_v[1:0]] = '{symbol_char(code_v), 1'b0, 1'b0};
                cnt_v  = cnt_v + 3'd1;
                prod_v = w_v ? {code_v, 1'b0} : {1'b0, code_v};
                sum_v  = sum_v + {4'd0, prod_v[5]} + prod_v[4:0];
                w_v    = !w_v;
                cig_v  = cig_v + 4'd1;
                if (cig_v == 4'(SPLIT_POINT)) begin
                    ent_next[cnt_v[1:0]] = '{DASH_CHAR, 1'b0, 1'b0};
                    cnt_v = cnt_v + 3'd1;
                end
                if (cig_v == 4'(GROUP_CHARS)) begin
                    fin_v = (grp_v == 2'(GROUP_COUNT - 1));
                    chk_v = 5'd0 - sum_v;
                    ent_next[cnt_v[1:0]] = '{symbol_char(chk_v), 1'b1, fin_v};
                    cnt_v = cnt_v + 3'd1;
                    if (!fin_v) begin
                        ent_next[cnt_v[1:0]] = '{DASH_CHAR, 1'b0, 1'b0};
                        cnt_v = cnt_v + 3'd1;
                    end
                    grp_v = grp_v + 2'd1;
                    cig_v = 4'd0;
                    sum_v = 5'd0;
                    w_v   = 1'b0;
                end
            end
        end

        cnt_next = cnt_v;
        if (last_byte) begin
            byte_index_next    = 5'd0;
            bit_buffer_next    = 4'd0;
            bits_held_next     = 4'd0;
            char_in_group_next = 4'd0;
            group_index_next   = 2'd0;
            check_sum_next     = 5'd0;
            weight_is_two_next = 1'b0;
        end else begin
            byte_index_next    = byte_index_reg + 5'd1;
            bit_buffer_next    = bits_v[3:0];
            bits_held_next     = held_v;
            char_in_group_next = cig_v;
            group_index_next   = grp_v;
            check_sum_next     = sum_v;
            weight_is_two_next = w_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            byte_index_reg    <= '0;
            bit_buffer_reg    <= '0;
            bits_held_reg     <= '0;
            char_in_group_reg <= '0;
            group_index_reg   <= '0;
            check_sum_reg     <= '0;
            weight_is_two_reg <= 1'b0;
            cnt_reg           <= '0;
            idx_reg           <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (load) begin
                in_valid_reg <= 1'b0;
            end
            if (load) begin
                byte_index_reg    <= byte_index_next;
                bit_buffer_reg    <= bit_buffer_next;
                bits_held_reg     <= bits_held_next;
                char_in_group_reg <= char_in_group_next;
                group_index_reg   <= group_index_next;
                check_sum_reg     <= check_sum_next;
                weight_is_two_reg <= weight_is_two_next;
                cnt_reg           <= cnt_next;
                idx_reg           <= '0;
            end else if (out_fire) begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_id_byte;
        end
        if (load) begin
            for (int i = 0; i < MAX_RESULTS; i++) begin
                ent_reg[i] <= ent_next[i];
            end
        end
    end

endmodule

// ===== tb/base32_id_luhn_formatter_unit_tb.sv =====
module base32_id_luhn_formatter_unit_tb;
    import b32l_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 16;
    localparam string ALPHABET = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_id_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [6:0] m_out_char;
    logic       m_is_check;
    logic       m_last_char;

    base32_id_luhn_formatter_unit uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_id_byte   (s_id_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_char  (m_out_char),
        .m_is_check  (m_is_check),
        .m_last_char (m_last_char)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // formatter state as seen by the predictor
    int unsigned bytes_taken = 0;
    logic [11:0] bit_acc = '0;
    logic [3:0]  bits_in_acc = '0;
    int unsigned syms_in_group = 0;
    int unsigned group_num = 0;
    logic [4:0]  luhn_sum = '0;
    logic        weight_two = 1'b0;

    entry_t expected_chars[$];

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int err_count = 0;
    int cycle_count = 0;

    function automatic logic [6:0] b32_char(input logic [4:0] code);
        return 7'(ALPHABET[code]);
    endfunction

    function automatic void push_char(input logic [6:0] ch, input logic chk,
                                      input logic last);
        entry_t e;
        e.out_char = ch;
        e.is_check = chk;
        e.last_char = last;
        expected_chars.push_back(e);
    endfunction

    function automatic void clear_format_state();
        bytes_taken = 0;
        bit_acc = '0;
        bits_in_acc = '0;
        syms_in_group = 0;
        group_num = 0;
        luhn_sum = '0;
        weight_two = 1'b0;
    endfunction

    function automatic void emit_symbol(input logic [4:0] code);
        logic [5:0] product;
        logic       final_group;
        push_char(b32_char(code), 1'b0, 1'b0);
        product = weight_two ? {code, 1'b0} : {1'b0, code};
        luhn_sum = luhn_sum + 5'(product[5]) + product[4:0];
        weight_two = ~weight_two;
        syms_in_group++;
        if (syms_in_group == SPLIT_POINT) begin
            push_char(DASH_CHAR, 1'b0, 1'b0);
        end
        if (syms_in_group >= GROUP_CHARS) begin
            final_group = (group_num >= GROUP_COUNT - 1);
            push_char(b32_char(5'd0 - luhn_sum), 1'b1, final_group);
            if (!final_group) begin
                push_char(DASH_CHAR, 1'b0, 1'b0);
            end
            group_num = (group_num + 1) % 4;
            syms_in_group = 0;
            luhn_sum = '0;
            weight_two = 1'b0;
        end
    endfunction

    function automatic void predict_chars(input logic [7:0] value);
        logic [4:0] code;
        bit_acc = {bit_acc[3:0], value};
        bits_in_acc = bits_in_acc + 4'd8;
        while (bits_in_acc >= 4'd5) begin
            code = 5'(bit_acc >> (bits_in_acc - 4'd5));
            bits_in_acc = bits_in_acc - 4'd5;
            bit_acc = bit_acc & ((12'd1 << bits_in_acc) - 12'd1);
            emit_symbol(code);
        end
        if (bytes_taken >= ID_BYTES - 1) begin
            if (bits_in_acc > 0) begin
                code = 5'(bit_acc << (4'd5 - bits_in_acc));
                emit_symbol(code);
            end
            clear_format_state();
        end else begin
            bytes_taken++;
        end
    endfunction

    // result channel: flow control and checking
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = LONG_HOLD;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        entry_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected transaction char=%h check=%b last=%b",
                         $time, m_out_char, m_is_check, m_last_char);
                err_count++;
            end else begin
                e = expected_chars.pop_front();
                if (m_out_char !== e.out_char) begin
                    $display("%0t: out_char expected %h actual %h",
                             $time, e.out_char, m_out_char);
                    err_count++;
                end
                if (m_is_check !== e.is_check) begin
                    $display("%0t: is_check expected %b actual %b",
                             $time, e.is_check, m_is_check);
                    err_count++;
                end
                if (m_last_char !== e.last_char) begin
                    $display("%0t: last_char expected %b actual %b",
                             $time, e.last_char, m_last_char);
                    err_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** base32_id_luhn_formatter_unit: FAILED **");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] value);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < tx_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_id_byte <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_chars(value);
    endtask

    task automatic wait_drained();
        while (expected_chars.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // zero group gives a zero check, a run of all-ones bytes the largest folded weights
    task automatic test_directed_extremes();
        logic [7:0] pattern[14] = '{8'h80, 8'h01, 8'h55, 8'hAA, 8'h7F, 8'hFE,
                                    8'h0F, 8'hF0, 8'h3C, 8'hC3, 8'h10, 8'h08,
                                    8'h42, 8'hBD};
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        for (int i = 0; i < 9; i++) send_byte(8'h00);
        for (int i = 0; i < 9; i++) send_byte(8'hFF);
        foreach (pattern[i]) send_byte(pattern[i]);
    endtask

    task automatic test_random_stream(input int tx_pct, input int rx_pct, input int count);
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        for (int i = 0; i < count; i++) send_byte(pick_byte());
    endtask

    task automatic test_backpressure_fill();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        hold_req = 1'b1;
        for (int i = 0; i < 24; i++) send_byte(pick_byte());
        s_valid <= 1'b0;
        wait_drained();
        for (int i = 0; i < 8; i++) send_byte(pick_byte());
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_extremes();
        test_random_stream(0, 0, 90);
        test_random_stream(85, 0, 90);
        test_random_stream(0, 85, 90);
        test_random_stream(35, 35, 90);
        test_backpressure_fill();

        s_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        if (err_count == 0 && expected_chars.size() == 0) begin
            $display("** base32_id_luhn_formatter_unit: PASSED **");
        end else begin
            $display("** base32_id_luhn_formatter_unit: FAILED **");
        end
        $finish;
    end

endmodule
